[sv/prgb_pkg.sv]
`timescale 1ns / 1ps
// prgb_pkg: shared types and constants of the prg bank / irq / multiplier block
// no dependencies

package prgb_pkg;

	// request kinds
	typedef enum logic [1:0] {
		ACT_CPU_WR   = 2'd0,
		ACT_CPU_RD   = 2'd1,
		ACT_PPU_WR   = 2'd2,
		ACT_SCANLINE = 2'd3
	} action_t;

	// window layout codes
	localparam logic [1:0] LAYOUT_32K   = 2'd0;
	localparam logic [1:0] LAYOUT_16K   = 2'd1;
	localparam logic [1:0] LAYOUT_MIXED = 2'd2;
	localparam logic [1:0] LAYOUT_8K    = 2'd3;

	localparam int NUM_WIN = 5;

	// register map
	localparam logic [15:0] ADDR_PRG_BASE  = 16'h6000;
	localparam logic [15:0] ADDR_XRAM_BASE = 16'h5C00;
	localparam logic [15:0] ADDR_LAYOUT    = 16'h5100;
	localparam logic [15:0] ADDR_BANK_LO   = 16'h5113;
	localparam logic [15:0] ADDR_BANK_HI   = 16'h5117;
	localparam logic [15:0] ADDR_IRQ_LINE  = 16'h5203;
	localparam logic [15:0] ADDR_IRQ_STAT  = 16'h5204;
	localparam logic [15:0] ADDR_MUL_LO    = 16'h5205;
	localparam logic [15:0] ADDR_MUL_HI    = 16'h5206;
	localparam logic [15:0] ADDR_PPU_MASK  = 16'h2001;

	localparam logic [2:0] WIN_FIRST_PAGE = 3'd3;
	localparam logic [2:0] BANK_SLOT_RAM  = 3'd0;
	localparam logic [2:0] BANK_SLOT_2    = 3'd2;
	localparam logic [2:0] BANK_SLOT_3    = 3'd3;
	localparam logic [2:0] BANK_SLOT_LAST = 3'd4;

	localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
	localparam logic [7:0] PPU_RENDER_MASK   = 8'h18;

	localparam logic [6:0] BANK_RST_W3 = 7'h7E;
	localparam logic [6:0] BANK_RST_W4 = 7'h7F;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] address;
		logic [7:0]  data;
		logic [8:0]  line_number;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_hit;
		logic        mem_request;
		logic        mem_mapped;
		logic        mem_is_ram;
		logic [6:0]  mem_bank;
		logic [12:0] mem_offset;
		logic        irq_line;
	} rsp_t;

	// one prg window entry
	typedef struct packed {
		logic [6:0] bank;
		logic       ram;
		logic       valid;
	} win_t;

	// bank register write towards the window table
	typedef struct packed {
		logic       en;
		logic [2:0] slot;
		logic [7:0] value;
	} bank_wr_t;

endpackage

[sv/prgb_xram.sv]
`timescale 1ns / 1ps
// prgb_xram: extra ram, single port, registered read, zero sweep after reset
// depends on nothing but the clock and reset

module prgb_xram #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata,
	output logic                       clr_done
);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW:0]   clr_cnt_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	assign clr_done  = clr_cnt_q[AW];
	assign mem_we    = !clr_done || (en && we);
	assign mem_addr  = clr_done ? addr : clr_cnt_q[AW-1:0];
	assign mem_wdata = clr_done ? wdata : 8'd0;
	assign rdata     = rdata_q;

	// one entry a cycle until the counter reaches the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (!clr_done) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (en && !we && clr_done) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

[sv/prgb_win.sv]
`timescale 1ns / 1ps
// prgb_win: five prg window entries, remapped on bank register writes
// depends on prgb_pkg

module prgb_win #(
	parameter bit HAS_PRG_RAM = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prgb_pkg::bank_wr_t bank_wr,
	input  logic [1:0]         layout,
	input  logic [2:0]         look_win,
	output prgb_pkg::win_t     look
);
	import prgb_pkg::*;

	win_t              win_q [NUM_WIN];
	win_t              win_d [NUM_WIN];
	logic [NUM_WIN-1:0] hit;
	logic [6:0]         bank;
	logic [2:0]         slot;
	logic               ram;
	logic               grp16;

	assign bank  = bank_wr.value[6:0];
	assign slot  = bank_wr.slot;
	assign ram   = !bank_wr.value[7] && (slot != BANK_SLOT_RAM) && (slot <= BANK_SLOT_3);
	assign grp16 = (layout == LAYOUT_16K) ||
		(layout == LAYOUT_MIXED && slot == BANK_SLOT_2);

	// which windows a bank write touches
	always_comb begin
		hit = '0;
		if (bank_wr.en) begin
			if (slot == BANK_SLOT_RAM) begin
				hit[0] = 1'b1;
			end else begin
				unique case (layout)
					LAYOUT_32K: begin
						if (slot == BANK_SLOT_LAST) hit[4:1] = 4'hF;
					end
					LAYOUT_16K: begin
						if (slot == BANK_SLOT_2) hit[2:1] = 2'b11;
						else if (slot == BANK_SLOT_LAST) hit[4:3] = 2'b11;
					end
					LAYOUT_MIXED: begin
						if (slot == BANK_SLOT_2) hit[2:1] = 2'b11;
						else if (slot == BANK_SLOT_3 || slot == BANK_SLOT_LAST) hit[slot] = 1'b1;
					end
					default: begin
						if (slot <= BANK_SLOT_LAST) hit[slot] = 1'b1;
					end
				endcase
			end
		end
	end

	// new contents of each window, aligned to the granule
	always_comb begin
		win_d[0] = '{bank: bank, ram: 1'b1, valid: HAS_PRG_RAM};
		for (int i = 1; i < NUM_WIN; i++) begin
			if (layout == LAYOUT_32K) win_d[i].bank = {bank[6:2], 2'(i - 1)};
			else if (grp16)           win_d[i].bank = {bank[6:1], 1'(i - 1)};
			else                      win_d[i].bank = bank;
			win_d[i].ram   = ram;
			win_d[i].valid = ram ? HAS_PRG_RAM : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '{bank: 7'd0, ram: 1'b1, valid: HAS_PRG_RAM};
			win_q[1] <= '{bank: 7'd0, ram: 1'b0, valid: 1'b0};
			win_q[2] <= '{bank: 7'd0, ram: 1'b0, valid: 1'b0};
			win_q[3] <= '{bank: BANK_RST_W3, ram: 1'b0, valid: 1'b1};
			win_q[4] <= '{bank: BANK_RST_W4, ram: 1'b0, valid: 1'b1};
		end else begin
			for (int i = 0; i < NUM_WIN; i++) begin
				if (hit[i]) win_q[i] <= win_d[i];
			end
		end
	end

	assign look = (look_win <= BANK_SLOT_LAST) ? win_q[look_win] : win_q[NUM_WIN-1];

endmodule

[sv/prg_bank_irq_multiplier_regs.sv]
`timescale 1ns / 1ps
// prg_bank_irq_multiplier_regs: cpu side of a bank-switching cartridge mapper
// depends on prgb_pkg, prgb_xram, prgb_win
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------
// req     | in        | req_valid, req_ready | prgb_pkg::req_t
// rsp     | out       | rsp_valid, rsp_ready | prgb_pkg::rsp_t
//
// one request per cycle while the response side does not stall; stage 1 holds the extra ram
// read, and the response register is loaded from stage 1 when it advances
// after reset the extra ram is swept to zero, req_ready low
// a stalled response holds the read stage; req_ready drops only when both are full

module prg_bank_irq_multiplier_regs #(
	parameter int EXTRA_RAM_DEPTH = 1024,
	parameter bit HAS_PRG_RAM     = 1'b1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  prgb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output prgb_pkg::rsp_t rsp
);
	import prgb_pkg::*;

	localparam int XAW = $clog2(EXTRA_RAM_DEPTH);

	// mapper registers
	logic [1:0] layout_q;
	logic [7:0] factor_a_q;
	logic [7:0] factor_b_q;
	logic [7:0] irq_target_q;
	logic       irq_enabled_q;
	logic       irq_pending_q;
	logic       irq_level_q;
	logic       vis_q;
	logic       render_on_q;

	// pipeline
	logic       s1_valid_q;
	rsp_t       res_s1;
	logic       xram_rd_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	rsp_t       s1_out;

	logic       acc;
	logic       s1_adv;
	logic       clr_done;
	logic       is_wr;
	logic       is_rd;
	logic       is_cpu;
	logic       hi_sel;
	logic       xram_sel;
	logic       bank_sel;
	logic [2:0] look_win;
	win_t       look;
	bank_wr_t   bank_wr;
	logic [7:0] xram_rdata;
	logic [15:0] prod;
	rsp_t       res_d;

	// next irq state
	logic       vis_d;
	logic       render_on_d;
	logic       pending_d;
	logic       level_d;
	logic       line_match;

	assign s1_adv    = !rsp_valid_q || rsp_ready;
	assign req_ready = clr_done && (!s1_valid_q || s1_adv);
	assign acc       = req_valid && req_ready;

	// address decode
	assign is_wr    = req.action == ACT_CPU_WR;
	assign is_rd    = req.action == ACT_CPU_RD;
	assign is_cpu   = is_wr || is_rd;
	assign hi_sel   = req.address >= ADDR_PRG_BASE;
	assign xram_sel = !hi_sel && req.address >= ADDR_XRAM_BASE;
	assign bank_sel = req.address >= ADDR_BANK_LO && req.address <= ADDR_BANK_HI;
	assign look_win = hi_sel ? (req.address[15:13] - WIN_FIRST_PAGE) : 3'd0;

	assign bank_wr.en    = acc && is_wr && bank_sel;
	assign bank_wr.slot  = 3'(req.address - ADDR_BANK_LO);
	assign bank_wr.value = req.data;

	prgb_win #(
		.HAS_PRG_RAM(HAS_PRG_RAM)
	) u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.bank_wr (bank_wr),
		.layout  (layout_q),
		.look_win(look_win),
		.look    (look)
	);

	// extra ram: writes land at acceptance, reads come back in stage 1
	prgb_xram #(
		.DEPTH(EXTRA_RAM_DEPTH)
	) u_xram (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (acc && is_cpu && xram_sel),
		.we      (is_wr),
		.addr    (req.address[XAW-1:0]),
		.wdata   (req.data),
		.rdata   (xram_rdata),
		.clr_done(clr_done)
	);

	assign prod       = factor_a_q * factor_b_q;
	assign line_match = {1'b0, irq_target_q} == req.line_number;

	// irq and render status after this request
	always_comb begin
		vis_d       = vis_q;
		render_on_d = render_on_q;
		pending_d   = irq_pending_q;
		level_d     = irq_level_q;
		case (req.action)
			ACT_CPU_RD: begin
				if (req.address == ADDR_IRQ_STAT) begin
					pending_d = 1'b0;
					level_d   = 1'b0;
				end
			end
			ACT_PPU_WR: begin
				if (req.address == ADDR_PPU_MASK) begin
					render_on_d = |(req.data & PPU_RENDER_MASK);
					if (!render_on_d) vis_d = 1'b0;
				end
			end
			ACT_SCANLINE: begin
				vis_d = (req.line_number <= LAST_VISIBLE_LINE) && render_on_q;
				if (line_match) begin
					pending_d = 1'b1;
					if (vis_d && irq_enabled_q && req.line_number != 9'd0) level_d = 1'b1;
				end else begin
					level_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// response fields known at acceptance; extra ram data joins in stage 1
	always_comb begin
		res_d = '0;
		if (is_cpu && hi_sel) begin
			res_d.mem_request = 1'b1;
			res_d.mem_mapped  = look.valid;
			res_d.mem_is_ram  = look.valid && look.ram;
			res_d.mem_bank    = look.valid ? look.bank : 7'd0;
			res_d.mem_offset  = req.address[12:0];
			res_d.read_hit    = is_rd && look.valid;
		end else if (is_rd) begin
			if (xram_sel) begin
				res_d.read_hit = 1'b1;
			end else if (req.address == ADDR_IRQ_STAT) begin
				res_d.read_data = {irq_pending_q, vis_q, 6'd0};
				res_d.read_hit  = 1'b1;
			end else if (req.address == ADDR_MUL_LO) begin
				res_d.read_data = prod[7:0];
				res_d.read_hit  = 1'b1;
			end else if (req.address == ADDR_MUL_HI) begin
				res_d.read_data = prod[15:8];
				res_d.read_hit  = 1'b1;
			end
		end
		res_d.irq_line = level_d;
	end

	// register file updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q      <= LAYOUT_8K;
			factor_a_q    <= '0;
			factor_b_q    <= '0;
			irq_target_q  <= '0;
			irq_enabled_q <= 1'b0;
			irq_pending_q <= 1'b0;
			irq_level_q   <= 1'b0;
			vis_q         <= 1'b0;
			render_on_q   <= 1'b0;
		end else if (acc) begin
			vis_q         <= vis_d;
			render_on_q   <= render_on_d;
			irq_pending_q <= pending_d;
			irq_level_q   <= level_d;
			if (is_wr && !hi_sel && !xram_sel) begin
				if (req.address == ADDR_LAYOUT)   layout_q      <= req.data[1:0];
				if (req.address == ADDR_IRQ_LINE) irq_target_q  <= req.data;
				if (req.address == ADDR_IRQ_STAT) irq_enabled_q <= req.data[7];
				if (req.address == ADDR_MUL_LO)   factor_a_q    <= req.data;
				if (req.address == ADDR_MUL_HI)   factor_b_q    <= req.data;
			end
		end
	end

	// stage 1 and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!s1_valid_q || s1_adv) s1_valid_q <= acc;
			if (s1_adv)                rsp_valid_q <= s1_valid_q;
		end
	end

	// stage 1 response with the extra ram byte merged in
	always_comb begin
		s1_out = res_s1;
		if (xram_rd_s1) s1_out.read_data = xram_rdata;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1     <= res_d;
			xram_rd_s1 <= is_rd && xram_sel;
		end
		if (s1_adv && s1_valid_q) begin
			rsp_q <= s1_out;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// no request taken during the ram sweep
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !req_ready)
		else $error("request accepted during extra ram sweep");

	// the irq line never stands without a pending flag
	a_level_pending: assert property (@(posedge clk) disable iff (!arst_n)
		irq_level_q |-> irq_pending_q)
		else $error("irq line high without pending");

	// visible-line flag only while rendering
	a_frame_render: assert property (@(posedge clk) disable iff (!arst_n)
		vis_q |-> render_on_q)
		else $error("visible-line flag set while rendering is off");

	// a held stage 1 stays full
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q)
		else $error("stage 1 request lost under stall");

	// window fields only on prg accesses
	a_mem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.mem_request |->
			!rsp_q.mem_mapped && !rsp_q.mem_is_ram && rsp_q.mem_bank == 7'd0)
		else $error("window fields set without prg access");

endmodule
